// ----- sv/ccfb_feedback_report_parser_defines.svh -----
// Assertion macros shared by the feedback report parser RTL.
`ifndef CCFB_FEEDBACK_REPORT_PARSER_DEFINES_SVH
`define CCFB_FEEDBACK_REPORT_PARSER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CCFB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccfb assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CCFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccfb assertion failed");

`endif

// ----- sv/ccfb_pkg.sv -----
// Types and constants of the congestion-control feedback report parser.
package ccfb_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ENTRY     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  // Arrival classes of a report entry.
  localparam logic [1:0] ClassNotReceived = 2'd0;
  localparam logic [1:0] ClassFinite      = 2'd1;
  localparam logic [1:0] ClassOverRange   = 2'd2;
  localparam logic [1:0] ClassUnavailable = 2'd3;

  localparam logic [12:0] AtoOverRange   = 13'h1FFE;
  localparam logic [12:0] AtoUnavailable = 13'h1FFF;

  // Smallest legal payload: sender SSRC plus timestamp.
  localparam logic [17:0] MinPayloadBytes = 18'd8;
  // A block start needs its SSRC word, its count word, one more word and the timestamp.
  localparam logic [15:0] BlockMinWords = 16'd4;

  // Default depth of the result queue; at least two.
  localparam int FifoDepth = 4;

  typedef struct packed {
    logic [31:0] payload_word;
    logic        first;
    logic [17:0] payload_bytes;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] stream_ssrc;
    logic [15:0] seq_number;
    logic [1:0]  arrival_class;
    logic [12:0] arrival_code;
    logic [1:0]  ecn_bits;
    logic [31:0] origin_ssrc;
    logic [31:0] report_timestamp;
    logic        last_of_item;
  } out_item_t;

endpackage

// ----- sv/ccfb_entry_lane.sv -----
// One report entry decoder lane: turns a 16-bit entry into a result item.
module ccfb_entry_lane (
  input  logic [15:0]         info_i,
  input  logic [31:0]         ssrc_i,
  input  logic [15:0]         seq_i,
  input  logic                last_i,
  output ccfb_pkg::out_item_t result_o
);

  logic [12:0] ato;

  assign ato = info_i[12:0];

  always_comb begin
    result_o               = '0;
    result_o.kind          = ccfb_pkg::KIND_ENTRY;
    result_o.stream_ssrc   = ssrc_i;
    result_o.seq_number    = seq_i;
    result_o.ecn_bits      = info_i[14:13];
    result_o.last_of_item  = last_i;
    result_o.arrival_class = ccfb_pkg::ClassNotReceived;
    // The offset is only reported for packets marked as received.
    if (info_i[15]) begin
      result_o.arrival_code = ato;
      if (ato == ccfb_pkg::AtoOverRange) begin
        result_o.arrival_class = ccfb_pkg::ClassOverRange;
      end else if (ato == ccfb_pkg::AtoUnavailable) begin
        result_o.arrival_class = ccfb_pkg::ClassUnavailable;
      end else begin
        result_o.arrival_class = ccfb_pkg::ClassFinite;
      end
    end
  end

endmodule

// ----- sv/ccfb_result_fifo.sv -----
// Result queue: takes up to two items a cycle, hands out one.
module ccfb_result_fifo #(
  parameter int Depth = ccfb_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push0_i,
  input  ccfb_pkg::out_item_t data0_i,
  input  logic                push1_i,
  input  ccfb_pkg::out_item_t data1_i,
  output logic                space2_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccfb_pkg::out_item_t out_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ccfb_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    ptr_inc = (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign space2_o    = (count_q <= CntW'(Depth - 2));
  assign wr_ptr_nx   = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push1_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

endmodule

// ----- sv/ccfb_feedback_report_parser.sv -----
// Top level of the congestion-control feedback report parser.
//
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) takes one
// 32-bit big-endian payload word per item. The item marked first carries
// the sender SSRC and the payload length in bytes. The output channel
// (out_valid_o, out_ready_i, out_data_o) delivers one result item per
// accepted handshake: a report entry, a done status with the sender SSRC and
// timestamp, or a malformed status. Each input word causes zero, one or two
// result items; last_of_item marks the final one of a word.
// Result items enter the result queue when their word is accepted and are offered in order behind queued items.
// Throughput: one word per cycle while the result queue has room for two
// more items; results leave at one per cycle while out_ready_i is high, so a run
// of entry words with two entries each is held back by the output port.
// Two decoder lanes handle the high and low entry of a word in parallel and
// the merge stage writes both into the result queue in the same cycle.
// Reset clears the parser to idle and empties the queue. When the receiver
// stalls, the queue fills and in_ready_o drops until space frees up; no
// item is lost or repeated.
module ccfb_feedback_report_parser #(
  parameter int FifoDepth = ccfb_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccfb_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccfb_pkg::out_item_t out_data_o
);

  `include "ccfb_feedback_report_parser_defines.svh"

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BLOCK   = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ENTRIES = 3'd3,
    PH_DROP    = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] words_left_q, words_left_d;
  logic [31:0] block_ssrc_q, block_ssrc_d;
  logic [15:0] base_seq_q, base_seq_d;
  logic [15:0] reports_left_q, reports_left_d;
  logic [15:0] report_index_q, report_index_d;
  logic [31:0] origin_ssrc_q, origin_ssrc_d;

  logic                in_fire;
  logic                space2;
  logic                push0, push1;
  ccfb_pkg::out_item_t res0, res1;
  ccfb_pkg::out_item_t lane0_res, lane1_res;
  logic [15:0]         seq0, seq1;
  logic                lane0_last;
  logic [31:0]         word;
  logic [17:0]         len;
  logic [15:0]         count_n;
  logic [16:0]         room2;

  assign in_ready_o = space2;
  assign in_fire    = in_valid_i && in_ready_o;
  assign word       = in_data_i.payload_word;
  assign len        = in_data_i.payload_bytes;
  assign count_n    = word[15:0];
  // Entries that still fit in the middle words after the count word.
  assign room2      = {words_left_q - 16'd2, 1'b0};

  // Entry lanes: the high half of the word is the earlier entry.
  assign seq0       = base_seq_q + report_index_q;
  assign seq1       = base_seq_q + report_index_q + 16'd1;
  assign lane0_last = (reports_left_q < 16'd2);

  ccfb_entry_lane u_lane0 (
    .info_i   (word[31:16]),
    .ssrc_i   (block_ssrc_q),
    .seq_i    (seq0),
    .last_i   (lane0_last),
    .result_o (lane0_res)
  );

  ccfb_entry_lane u_lane1 (
    .info_i   (word[15:0]),
    .ssrc_i   (block_ssrc_q),
    .seq_i    (seq1),
    .last_i   (1'b1),
    .result_o (lane1_res)
  );

  // Parser state machine and merge of the lane results.
  always_comb begin
    phase_d        = phase_q;
    words_left_d   = words_left_q;
    block_ssrc_d   = block_ssrc_q;
    base_seq_d     = base_seq_q;
    reports_left_d = reports_left_q;
    report_index_d = report_index_q;
    origin_ssrc_d  = origin_ssrc_q;
    push0          = 1'b0;
    push1          = 1'b0;
    res0           = '0;
    res1           = lane1_res;
    res0.last_of_item = 1'b1;

    if (in_fire) begin
      if (in_data_i.first) begin
        // A first word always restarts, abandoning any packet in progress.
        if (len[1:0] != 2'b00 || len < ccfb_pkg::MinPayloadBytes) begin
          words_left_d = '0;
          res0.kind    = ccfb_pkg::KIND_MALFORMED;
          push0        = 1'b1;
          phase_d      = PH_DROP;
        end else begin
          origin_ssrc_d = word;
          words_left_d  = len[17:2] - 16'd1;
          phase_d       = PH_BLOCK;
        end
      end else if (phase_q != PH_IDLE && phase_q != PH_DROP && words_left_q != '0) begin
        words_left_d = words_left_q - 16'd1;
        case (phase_q)
          PH_BLOCK: begin
            if (words_left_q <= 16'd1) begin
              // This is the timestamp word that closes the packet.
              res0.kind             = ccfb_pkg::KIND_DONE;
              res0.origin_ssrc      = origin_ssrc_q;
              res0.report_timestamp = word;
              push0                 = 1'b1;
              phase_d               = PH_IDLE;
            end else if (words_left_q < ccfb_pkg::BlockMinWords) begin
              // Leftover words too few for another block.
              res0.kind = ccfb_pkg::KIND_MALFORMED;
              push0     = 1'b1;
              phase_d   = PH_DROP;
            end else begin
              block_ssrc_d = word;
              phase_d      = PH_COUNT;
            end
          end
          PH_COUNT: begin
            base_seq_d     = word[31:16];
            report_index_d = '0;
            reports_left_d = count_n;
            if ({1'b0, count_n} > room2) begin
              res0.kind = ccfb_pkg::KIND_MALFORMED;
              push0     = 1'b1;
              phase_d   = PH_DROP;
            end else begin
              phase_d = (count_n == '0) ? PH_BLOCK : PH_ENTRIES;
            end
          end
          PH_ENTRIES: begin
            res0  = lane0_res;
            push0 = 1'b1;
            if (reports_left_q >= 16'd2) begin
              push1          = 1'b1;
              report_index_d = report_index_q + 16'd2;
              reports_left_d = reports_left_q - 16'd2;
              if (reports_left_q == 16'd2) begin
                phase_d = PH_BLOCK;
              end
            end else begin
              // Odd count: the low half of this word is padding.
              report_index_d = report_index_q + 16'd1;
              reports_left_d = reports_left_q - 16'd1;
              phase_d        = PH_BLOCK;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      words_left_q   <= '0;
      block_ssrc_q   <= '0;
      base_seq_q     <= '0;
      reports_left_q <= '0;
      report_index_q <= '0;
      origin_ssrc_q  <= '0;
    end else begin
      phase_q        <= phase_d;
      words_left_q   <= words_left_d;
      block_ssrc_q   <= block_ssrc_d;
      base_seq_q     <= base_seq_d;
      reports_left_q <= reports_left_d;
      report_index_q <= report_index_d;
      origin_ssrc_q  <= origin_ssrc_d;
    end
  end

  ccfb_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .data0_i     (res0),
    .push1_i     (push1),
    .data1_i     (res1),
    .space2_o    (space2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The second lane only ever writes alongside the first.
  `CCFB_ASSERT_IMPL(a_push_pair, push1, push0)
  // Words of a dropped packet never produce results.
  `CCFB_ASSERT_IMPL(a_drop_silent, in_fire && !in_data_i.first && phase_q == PH_DROP, !push0)
  // After a too-short length is accepted, the result queue offers an item on the very next cycle.
  `CCFB_ASSERT_NEXT(a_short_len, in_fire && in_data_i.first && in_data_i.payload_bytes < ccfb_pkg::MinPayloadBytes, out_valid_o)

endmodule
